@@ rtl/lstd_pkg.sv @@
// shared types, constants and the crc byte fold for the scan telegram deframer
// no dependencies
`timescale 1ns / 1ps

package lstd_pkg;

  localparam int unsigned WinLen  = 24;
  localparam int unsigned FoldFirst = 4;
  localparam int unsigned FoldLen = WinLen - FoldFirst;
  localparam int unsigned FoldCntW = $clog2(FoldLen);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [10:0] FRAME_BYTES_RST = 11'd1548;
  localparam logic [10:0] MEAS_OFFSET_RST = 11'd24;
  localparam logic [10:0] FRAME_BYTES_MIN = 11'd32;
  localparam logic [10:0] MEAS_OFFSET_MIN = 11'd24;
  localparam logic [10:0] FRAME_START_POS = 11'(WinLen);
  localparam logic [9:0]  NUM_MEAS        = 10'd761;

  // start pattern bytes
  localparam logic [7:0] PAT_FF = 8'hFF;
  localparam logic [7:0] PAT_07 = 8'h07;
  localparam logic [7:0] PAT_02 = 8'h02;
  localparam logic [7:0] PAT_01 = 8'h01;
  localparam logic [7:0] PAT_00 = 8'h00;
  localparam logic [7:0] PAT_BB = 8'hBB;
  localparam logic [7:0] PAT_11 = 8'h11;

  // register indexes
  localparam logic CFG_FRAME_BYTES = 1'b0;
  localparam logic CFG_MEAS_OFFSET = 1'b1;

  // result kinds
  localparam logic KIND_DIST   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic       shift;    // advance window by one byte
    logic       clear;    // back to all zero
    logic [7:0] fill;     // byte entering at the newest end
  } win_ctrl_t;

  // msb-first crc-16 fold of one byte, eight narrow steps
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/lstd_crc_unit.sv @@
// shared crc-16 fold unit, one byte per cycle
// depends on lstd_pkg
`timescale 1ns / 1ps

module lstd_crc_unit
  import lstd_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  assign crc_o = crc_fold(crc_i, byte_i);

endmodule

@@ rtl/lstd_window.sv @@
// 24-byte hunting window with start pattern detector
// depends on lstd_pkg
`timescale 1ns / 1ps

module lstd_window
  import lstd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  win_ctrl_t ctrl_i,
  output logic [7:0] head_o,   // byte at the first folded position
  output logic      match_o
);

  logic [7:0] win_q [WinLen];
  logic       zeros_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinLen; k++) win_q[k] <= '0;
    end else if (ctrl_i.clear) begin
      for (int k = 0; k < WinLen; k++) win_q[k] <= '0;
    end else if (ctrl_i.shift) begin
      for (int k = 0; k < WinLen - 1; k++) win_q[k] <= win_q[k+1];
      win_q[WinLen-1] <= ctrl_i.fill;
    end
  end

  always_comb begin
    zeros_ok = 1'b1;
    for (int k = 0; k < 6; k++) begin
      if (win_q[k] != PAT_00) zeros_ok = 1'b0;
    end
  end

  assign match_o = zeros_ok &&
                   win_q[8] == PAT_FF && win_q[9] == PAT_07 &&
                   win_q[10] == PAT_02 && win_q[11] == PAT_01 &&
                   win_q[12] == PAT_00 && win_q[13] == PAT_00 &&
                   win_q[20] == PAT_BB && win_q[21] == PAT_BB &&
                   win_q[22] == PAT_11 && win_q[23] == PAT_11;

  assign head_o = win_q[FoldFirst];

endmodule

@@ rtl/laser_scan_telegram_deframer_core.sv @@
// top level of the scan telegram deframer: sequencer, registers, output stage
// depends on lstd_pkg, lstd_crc_unit, lstd_window
`timescale 1ns / 1ps

// Takes the scanner's received byte stream one byte at a time and hunts for the
// telegram start pattern in a 24-byte window. A byte inside a telegram is
// captured, then makes one pass through the shared crc unit and sequencer; a
// byte while hunting is captured, shifted into the window and pattern checked,
// and for the byte that completes the start pattern the crc unit then folds
// the 20 window bytes one per cycle. s_axis_tready is low while a byte is in
// work and while a result word cannot be placed because the previous one still
// waits. Inside a telegram every 16-bit little-endian word from meas_offset on
// gives a distance word (kind 0, up to 761 per telegram); the last telegram
// byte gives a status word (kind 1) with crc_ok and the computed crc, after
// which the block hunts again. Downstream should discard a telegram's distances
// unless crc_ok is set. frame_bytes below 32 acts as 32, meas_offset below 24
// as 24. Registers take effect at once and should be written while idle.

module laser_scan_telegram_deframer_core
  import lstd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  // result words out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // meas_index[9:0], distance_cm[22:10],
                                      // crc_ok[23], computed_crc[39:24]
  output logic        m_axis_tuser,   // kind
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STEP  = 4'b0010,
    S_CHECK = 4'b0100,
    S_FOLD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [10:0] frame_bytes_q, meas_offset_q;
  logic [7:0]  byte_q;
  logic        in_frame_q, in_frame_d;
  logic [10:0] pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  lo_hold_q, lo_hold_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [9:0]  meas_cnt_q, meas_cnt_d;
  logic [FoldCntW-1:0] fold_cnt_q, fold_cnt_d;

  logic        out_valid_q, out_valid_d;
  logic        out_kind_q, out_kind_d;
  logic [39:0] out_data_q, out_data_d;

  win_ctrl_t   win_ctrl;
  logic [7:0]  win_head;
  logic        win_match;
  logic [7:0]  crc_byte;
  logic [15:0] crc_next;

  logic [10:0] len, off;
  logic [11:0] pos_inc;
  logic        is_last, is_crc_lo, meas_ok, hi_byte, emit, out_free;
  logic [15:0] rx_crc;

  // register port, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= FRAME_BYTES_RST;
      meas_offset_q <= MEAS_OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_BYTES: frame_bytes_q <= cfg_data_i;
        CFG_MEAS_OFFSET: meas_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lstd_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .head_o  (win_head),
    .match_o (win_match)
  );

  // the one crc unit: telegram bytes in S_STEP, window bytes in S_FOLD
  assign crc_byte = (state_q == S_FOLD) ? win_head : byte_q;

  lstd_crc_unit u_crc (
    .crc_i  (crc_q),
    .byte_i (crc_byte),
    .crc_o  (crc_next)
  );

  // clamped registers and frame position decode
  assign len       = (frame_bytes_q < FRAME_BYTES_MIN) ? FRAME_BYTES_MIN : frame_bytes_q;
  assign off       = (meas_offset_q < MEAS_OFFSET_MIN) ? MEAS_OFFSET_MIN : meas_offset_q;
  assign pos_inc   = {1'b0, pos_q} + 12'd1;
  assign is_last   = pos_inc >= {1'b0, len};
  assign is_crc_lo = (pos_inc + 12'd1) == {1'b0, len};
  assign meas_ok   = (pos_q >= off) && (meas_cnt_q < NUM_MEAS);
  assign hi_byte   = pos_q[0] ^ off[0];
  assign emit      = is_last || (meas_ok && hi_byte);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign rx_crc    = {byte_q, crc_lo_q};

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    in_frame_d  = in_frame_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    lo_hold_d   = lo_hold_q;
    crc_lo_d    = crc_lo_q;
    meas_cnt_d  = meas_cnt_q;
    fold_cnt_d  = fold_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    win_ctrl    = '{shift: 1'b0, clear: 1'b0, fill: 8'h00};

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_STEP;
      end

      S_STEP: begin
        if (!in_frame_q) begin
          win_ctrl = '{shift: 1'b1, clear: 1'b0, fill: byte_q};
          state_d  = S_CHECK;
        end else if (!emit) begin
          if (is_crc_lo) crc_lo_d = byte_q;
          else           crc_d    = crc_next;
          pos_d = pos_inc[10:0];
          if (meas_ok) lo_hold_d = byte_q;
          state_d = S_IDLE;
        end else if (out_free) begin
          // result word goes out; wait here while the stage is still full
          out_valid_d = 1'b1;
          if (is_last) begin
            out_kind_d  = KIND_STATUS;
            out_data_d  = {crc_q, rx_crc == crc_q, 13'd0, meas_cnt_q};
            win_ctrl    = '{shift: 1'b0, clear: 1'b1, fill: 8'h00};
            in_frame_d  = 1'b0;
            pos_d       = '0;
            crc_d       = CRC_INIT;
            lo_hold_d   = '0;
            crc_lo_d    = '0;
            meas_cnt_d  = '0;
          end else begin
            if (is_crc_lo) crc_lo_d = byte_q;
            else           crc_d    = crc_next;
            pos_d       = pos_inc[10:0];
            out_kind_d  = KIND_DIST;
            out_data_d  = {16'd0, 1'b0, byte_q[4:0], lo_hold_q, meas_cnt_q};
            meas_cnt_d  = meas_cnt_q + 10'd1;
          end
          state_d = S_IDLE;
        end
      end

      S_CHECK: begin
        if (win_match) begin
          crc_d      = CRC_INIT;
          fold_cnt_d = '0;
          state_d    = S_FOLD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_FOLD: begin
        // window bytes 4..23 pass the head tap in order
        crc_d    = crc_next;
        win_ctrl = '{shift: 1'b1, clear: 1'b0, fill: 8'h00};
        fold_cnt_d = fold_cnt_q + FoldCntW'(1);
        if (fold_cnt_q == FoldCntW'(FoldLen - 1)) begin
          in_frame_d = 1'b1;
          pos_d      = FRAME_START_POS;
          meas_cnt_d = '0;
          lo_hold_d  = '0;
          crc_lo_d   = '0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_frame_q  <= 1'b0;
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      lo_hold_q   <= '0;
      crc_lo_q    <= '0;
      meas_cnt_q  <= '0;
      fold_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_frame_q  <= in_frame_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      lo_hold_q   <= lo_hold_d;
      crc_lo_q    <= crc_lo_d;
      meas_cnt_q  <= meas_cnt_d;
      fold_cnt_q  <= fold_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) byte_q <= s_axis_tdata;
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // fold only ever starts from hunting
  a_fold_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FOLD |-> !in_frame_q)
    else $error("crc fold while inside a telegram");

  // inside a telegram the position never falls below the window length
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> pos_q >= FRAME_START_POS)
    else $error("frame position below window length");

  // distance count bounded per telegram
  a_meas_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_cnt_q <= NUM_MEAS)
    else $error("too many distances in one telegram");

  // a placed status word ends the telegram
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && in_frame_q && is_last && out_free)
      |=> (!in_frame_q && m_axis_tvalid && m_axis_tuser == KIND_STATUS))
    else $error("status word without return to hunting");

endmodule
